/* rtl/core/rlf_pkg.sv */
// Shared types and constants for the RGB linear fade engine.
// No dependencies; compiled first.
`default_nettype none

package rlf_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int INT_W         = 8;
  localparam int FUNC_W        = 2;
  localparam int DUR_W         = 16;
  localparam int IVL_W         = 10;
  localparam int NUM_LANES     = 3;

  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(20);
  localparam logic [INT_W-1:0] COLOR_MAX = INT_W'(255);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START   = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CNT  = 4'b0010,
    ST_STEP = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  // control from the sequencer to one channel lane
  typedef struct packed {
    logic load_goal;
    logic snap;
    logic tick;
    logic div_start;
  } lane_ctrl_t;

  // status from one channel lane to the merge logic
  typedef struct packed {
    logic match;
    logic div_done;
  } lane_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rlf_if.sv */
// Valid/ready channel interfaces of the fade engine: command, result, config.
// Depends on rlf_pkg for the field widths.
`default_nettype none

interface rlf_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [rlf_pkg::FUNC_W-1:0]    func;
  logic [rlf_pkg::INT_W-1:0]     target_red;
  logic [rlf_pkg::INT_W-1:0]     target_green;
  logic [rlf_pkg::INT_W-1:0]     target_blue;
  logic [rlf_pkg::DUR_W-1:0]     duration_ms;

  modport source (output valid, func, target_red, target_green, target_blue, duration_ms,
                  input ready);
  modport sink   (input valid, func, target_red, target_green, target_blue, duration_ms,
                  output ready);
endinterface

interface rlf_res_if;
  logic                          valid;
  logic                          ready;
  logic [rlf_pkg::INT_W-1:0]     red_out;
  logic [rlf_pkg::INT_W-1:0]     green_out;
  logic [rlf_pkg::INT_W-1:0]     blue_out;
  logic                          done_res;
  logic                          running_out;

  modport source (output valid, red_out, green_out, blue_out, done_res, running_out,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, done_res, running_out,
                  output ready);
endinterface

interface rlf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rlf_pkg::IVL_W-1:0]     update_interval_ms;

  modport source (output valid, update_interval_ms, input ready);
  modport sink   (input valid, update_interval_ms, output ready);
endinterface

`default_nettype wire

/* rtl/core/rlf_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; used for the step count and by each channel lane.
`default_nettype none

module rlf_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;

  logic [DEN_W:0]   partial;
  logic [DEN_W:0]   trial;
  logic             ge;

  // shift the next dividend bit into the remainder, subtract if it fits
  assign partial = {rem_q, quot_q[NUM_W-1]};
  assign trial   = partial - {1'b0, den_q};
  assign ge      = partial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quot_d = {quot_q[NUM_W-2:0], ge};
      rem_d  = ge ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/core/rlf_lane.sv */
// One color channel: fixed-point level, signed step, goal and step divider.
// Depends on rlf_pkg and rlf_div.
`default_nettype none

module rlf_lane #(
  parameter int FRAC_BITS = rlf_pkg::FRAC_BITS_DEF,
  parameter int STEPS_W   = rlf_pkg::DUR_W
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rlf_pkg::lane_ctrl_t         ctrl_i,
  input  wire logic [rlf_pkg::INT_W-1:0]   goal_i,
  input  wire logic [STEPS_W-1:0]          steps_i,
  output logic [rlf_pkg::INT_W-1:0]        color_o,
  output rlf_pkg::lane_stat_t              stat_o
);

  localparam int LVL_W = rlf_pkg::INT_W + FRAC_BITS;
  localparam int STP_W = LVL_W + 1;
  localparam int SUM_W = LVL_W + 2;
  localparam logic [LVL_W-1:0] LEVEL_MAX = {rlf_pkg::COLOR_MAX, {FRAC_BITS{1'b0}}};

  logic [rlf_pkg::INT_W-1:0] goal_q, goal_d;
  logic [LVL_W-1:0]          level_q, level_d;
  logic signed [STP_W-1:0]   step_q, step_d;
  logic                      neg_q, neg_d;
  logic                      zero_q, zero_d;

  logic [rlf_pkg::INT_W-1:0] int_q;
  logic                      neg;
  logic [rlf_pkg::INT_W-1:0] mag_int;
  logic [LVL_W-1:0]          mag;
  logic                      div_done;
  logic [LVL_W-1:0]          quot;
  logic [LVL_W-1:0]          qmin;
  logic signed [SUM_W-1:0]   sum;
  logic [LVL_W-1:0]          adv;

  assign int_q   = level_q[LVL_W-1 -: rlf_pkg::INT_W];
  assign neg     = goal_q < int_q;
  assign mag_int = neg ? (int_q - goal_q) : (goal_q - int_q);
  assign mag     = {mag_int, {FRAC_BITS{1'b0}}};

  rlf_div #(
    .NUM_W (LVL_W),
    .DEN_W (STEPS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.div_start),
    .num_i   (mag),
    .den_i   (steps_i),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // a nonzero distance always moves at least one LSB per tick
  assign qmin = (quot == '0) ? LVL_W'(1) : quot;

  // level plus step, then clamp to 0 .. 255.0
  assign sum = $signed({2'b00, level_q}) + SUM_W'(step_q);
  always_comb begin
    if (sum < 0) begin
      adv = '0;
    end else if (sum > $signed({2'b00, LEVEL_MAX})) begin
      adv = LEVEL_MAX;
    end else begin
      adv = sum[LVL_W-1:0];
    end
  end

  always_comb begin
    goal_d  = goal_q;
    level_d = level_q;
    step_d  = step_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    if (ctrl_i.load_goal) begin
      goal_d = goal_i;
    end
    if (ctrl_i.snap) begin
      level_d = {int_q, {FRAC_BITS{1'b0}}};
    end else if (ctrl_i.tick && (int_q != goal_q)) begin
      level_d = adv;
    end
    if (ctrl_i.div_start) begin
      neg_d  = neg;
      zero_d = (mag_int == '0);
    end
    if (div_done) begin
      if (zero_q) begin
        step_d = '0;
      end else if (neg_q) begin
        step_d = -$signed({1'b0, qmin});
      end else begin
        step_d = $signed({1'b0, qmin});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q  <= '0;
      level_q <= '0;
      step_q  <= '0;
      neg_q   <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      goal_q  <= goal_d;
      level_q <= level_d;
      step_q  <= step_d;
      neg_q   <= neg_d;
      zero_q  <= zero_d;
    end
  end

  assign color_o         = level_d[LVL_W-1 -: rlf_pkg::INT_W];
  assign stat_o.match    = (level_d[LVL_W-1 -: rlf_pkg::INT_W] == goal_q);
  assign stat_o.div_done = div_done;

endmodule

`default_nettype wire

/* rtl/core/rgb_linear_fade_engine.sv */
// Top level of the RGB linear fade engine: sequencer, three channel lanes, merge.
// Depends on rlf_pkg, rlf_if, rlf_div and rlf_lane.
`default_nettype none

// RGB linear fade engine. Each command transfer yields exactly one result
// transfer carrying the current color, done and running flags. Ticks, idle
// ticks and the unused func code are answered from the idle state: the
// result is loaded into the output register at the same edge the command is
// taken, so a tick can be taken every cycle while results drain and the
// result channel is ready. A start or restart first divides the duration by
// the tick interval in a serial divider, then the three lanes divide their
// color distance (8+FRAC_BITS bits) by that step count in parallel, one
// quotient bit per cycle. Until those divides end and the result is loaded,
// the command channel is not ready. The interval register may be written at
// any time the block is idle; a value of zero acts as one. The config channel
// is always ready.

module rgb_linear_fade_engine #(
  parameter int FRAC_BITS = rlf_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rlf_cfg_if.sink     cfg_i,
  rlf_cmd_if.sink     cmd_i,
  rlf_res_if.source   res_o
);

  localparam int INT_W = rlf_pkg::INT_W;

  rlf_pkg::state_e state_q, state_d;

  logic [rlf_pkg::IVL_W-1:0] interval_q, interval_d;
  logic [rlf_pkg::DUR_W-1:0] dur_q, dur_d;
  logic                      running_q, running_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [INT_W-1:0] red_q, red_d;
  logic [INT_W-1:0] green_q, green_d;
  logic [INT_W-1:0] blue_q, blue_d;
  logic             done_q, done_d;
  logic             run_out_q, run_out_d;

  logic out_free;
  logic cmd_take;
  logic is_start, is_restart, is_tick;
  logic take_fade;
  logic tick_live;

  // step-count divider
  logic [rlf_pkg::DUR_W-1:0] cnt_num;
  logic [rlf_pkg::IVL_W-1:0] cnt_den;
  logic                      cnt_done;
  logic [rlf_pkg::DUR_W-1:0] cnt_quot;
  logic [rlf_pkg::DUR_W-1:0] steps;

  // lanes and merge
  rlf_pkg::lane_ctrl_t lane_ctrl;
  rlf_pkg::lane_stat_t lane_stat [rlf_pkg::NUM_LANES];
  logic [INT_W-1:0]    lane_goal [rlf_pkg::NUM_LANES];
  logic [INT_W-1:0]    lane_color [rlf_pkg::NUM_LANES];
  logic                all_match;
  logic                all_div_done;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign out_free    = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == rlf_pkg::ST_IDLE) && out_free;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  assign is_start   = (cmd_i.func == rlf_pkg::FUNC_START);
  assign is_restart = (cmd_i.func == rlf_pkg::FUNC_RESTART);
  assign is_tick    = (cmd_i.func == rlf_pkg::FUNC_TICK);
  assign take_fade  = cmd_take && (is_start || is_restart);
  assign tick_live  = cmd_take && is_tick && running_q;

  // ---------------------------------------------------------------------------
  // Step count = max(1, duration / max(1, interval))
  // ---------------------------------------------------------------------------
  assign cnt_num = is_start ? cmd_i.duration_ms : dur_q;
  assign cnt_den = (interval_q == '0) ? rlf_pkg::IVL_W'(1) : interval_q;

  rlf_div #(
    .NUM_W (rlf_pkg::DUR_W),
    .DEN_W (rlf_pkg::IVL_W)
  ) u_cnt_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (take_fade),
    .num_i   (cnt_num),
    .den_i   (cnt_den),
    .done_o  (cnt_done),
    .quot_o  (cnt_quot)
  );

  assign steps = (cnt_quot == '0) ? rlf_pkg::DUR_W'(1) : cnt_quot;

  // ---------------------------------------------------------------------------
  // Channel lanes
  // ---------------------------------------------------------------------------
  assign lane_ctrl.load_goal = cmd_take && is_start;
  assign lane_ctrl.snap      = take_fade;
  assign lane_ctrl.tick      = tick_live;
  assign lane_ctrl.div_start = cnt_done;

  assign lane_goal[0] = cmd_i.target_red;
  assign lane_goal[1] = cmd_i.target_green;
  assign lane_goal[2] = cmd_i.target_blue;

  for (genvar g = 0; g < rlf_pkg::NUM_LANES; g++) begin : g_lane
    rlf_lane #(
      .FRAC_BITS (FRAC_BITS),
      .STEPS_W   (rlf_pkg::DUR_W)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .goal_i  (lane_goal[g]),
      .steps_i (steps),
      .color_o (lane_color[g]),
      .stat_o  (lane_stat[g])
    );
  end

  // merge: the fade ends when every channel sits on its goal
  assign all_match    = lane_stat[0].match && lane_stat[1].match && lane_stat[2].match;
  assign all_div_done = lane_stat[0].div_done && lane_stat[1].div_done &&
                        lane_stat[2].div_done;

  // ---------------------------------------------------------------------------
  // Sequencer and state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    interval_d  = interval_q;
    dur_d       = dur_q;
    running_d   = running_q;
    out_valid_d = out_valid_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    done_d      = done_q;
    run_out_d   = run_out_q;

    if (cfg_i.valid) begin
      interval_d = cfg_i.update_interval_ms;
    end

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rlf_pkg::ST_IDLE: begin
        if (take_fade) begin
          running_d = 1'b1;
          if (is_start) begin
            dur_d = cmd_i.duration_ms;
          end
          state_d = rlf_pkg::ST_CNT;
        end else if (cmd_take) begin
          // tick, idle tick or unused code: answer right away
          if (tick_live && all_match) begin
            running_d = 1'b0;
          end
          out_valid_d = 1'b1;
          red_d       = lane_color[0];
          green_d     = lane_color[1];
          blue_d      = lane_color[2];
          done_d      = tick_live && all_match;
          run_out_d   = running_q && !(tick_live && all_match);
        end
      end
      rlf_pkg::ST_CNT: begin
        if (cnt_done) begin
          state_d = rlf_pkg::ST_STEP;
        end
      end
      rlf_pkg::ST_STEP: begin
        if (all_div_done) begin
          state_d = rlf_pkg::ST_RESP;
        end
      end
      rlf_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          red_d       = lane_color[0];
          green_d     = lane_color[1];
          blue_d      = lane_color[2];
          done_d      = 1'b0;
          run_out_d   = 1'b1;
          state_d     = rlf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rlf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlf_pkg::ST_IDLE;
      interval_q  <= rlf_pkg::IVL_RESET;
      dur_q       <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      interval_q  <= interval_d;
      dur_q       <= dur_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q     <= red_d;
    green_q   <= green_d;
    blue_q    <= blue_d;
    done_q    <= done_d;
    run_out_q <= run_out_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.red_out     = red_q;
  assign res_o.green_out   = green_q;
  assign res_o.blue_out    = blue_q;
  assign res_o.done_res    = done_q;
  assign res_o.running_out = run_out_q;

endmodule

`default_nettype wire

/* sim/rlf_fade_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the RGB linear fade engine: watches the config, command and result
// channels, predicts every result and compares it. Depends on rlf_pkg and rlf_if.

module rlf_fade_checker
  import rlf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  rlf_cfg_if   cfg_i,
  rlf_cmd_if   cmd_i,
  rlf_res_if   res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   fades_done_o
);

  localparam int LEVEL_W   = INT_W + FRAC_BITS;
  localparam int RATE_W    = LEVEL_W + 1;
  localparam int LEVEL_TOP = int'(COLOR_MAX) << FRAC_BITS;

  typedef struct packed {
    logic [INT_W-1:0] red;
    logic [INT_W-1:0] green;
    logic [INT_W-1:0] blue;
    logic             done;
    logic             running;
  } color_rec_t;

  logic [IVL_W-1:0]         interval;
  logic [DUR_W-1:0]         fade_ms;
  logic [INT_W-1:0]         goal  [NUM_LANES];
  logic [LEVEL_W-1:0]       level [NUM_LANES];
  logic signed [RATE_W-1:0] rate  [NUM_LANES];
  logic                     fading;
  color_rec_t               expected_colors[$];

  function automatic logic [INT_W-1:0] whole(logic [LEVEL_W-1:0] lv);
    return lv[LEVEL_W-1:FRAC_BITS];
  endfunction

  // per-tick increment, at least one LSB toward the goal
  function automatic logic signed [RATE_W-1:0] lane_rate(logic [INT_W-1:0] tgt,
                                                          logic [INT_W-1:0] now,
                                                          int unsigned n_steps);
    int          diff;
    int unsigned q;
    diff = int'(tgt) - int'(now);
    if (diff == 0) return '0;
    q = ((diff < 0) ? -diff : diff) << FRAC_BITS;
    q = q / n_steps;
    if (q == 0) q = 1;
    return (diff < 0) ? -RATE_W'(q) : RATE_W'(q);
  endfunction

  function void start_fade();
    int unsigned per_tick;
    int unsigned n_steps;
    per_tick = (interval == '0) ? 1 : interval;
    n_steps  = fade_ms / per_tick;
    if (n_steps < 1) n_steps = 1;
    for (int i = 0; i < NUM_LANES; i++) begin
      level[i][FRAC_BITS-1:0] = '0;
      rate[i] = lane_rate(goal[i], whole(level[i]), n_steps);
    end
    fading = 1'b1;
  endfunction

  // returns 1 when all lanes sit on their goal after the step
  function logic tick_lanes();
    int   v;
    logic arrived;
    arrived = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (whole(level[i]) != goal[i]) begin
        v = int'(level[i]) + int'(rate[i]);
        if (v < 0) v = 0;
        if (v > LEVEL_TOP) v = LEVEL_TOP;
        level[i] = LEVEL_W'(v);
      end
      if (whole(level[i]) != goal[i]) arrived = 1'b0;
    end
    if (arrived) fading = 1'b0;
    return arrived;
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    color_rec_t seen;
    color_rec_t want;
    logic       hit;
    if (!rst_ni) begin
      interval = IVL_RESET;
      fade_ms  = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        goal[i]  = '0;
        level[i] = '0;
        rate[i]  = '0;
      end
      fading = 1'b0;
      expected_colors.delete();
      fail_count_o = 0;
      pending_o    = 0;
      fades_done_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) interval = cfg_i.update_interval_ms;

      // result first: a command taken at this edge cannot have its result out yet
      if (res_i.valid && res_i.ready) begin
        seen.red     = res_i.red_out;
        seen.green   = res_i.green_out;
        seen.blue    = res_i.blue_out;
        seen.done    = res_i.done_res;
        seen.running = res_i.running_out;
        if (expected_colors.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o++;
        end else begin
          want = expected_colors.pop_front();
          compare_field("red_out", want.red, seen.red);
          compare_field("green_out", want.green, seen.green);
          compare_field("blue_out", want.blue, seen.blue);
          compare_field("done_res", want.done, seen.done);
          compare_field("running_out", want.running, seen.running);
        end
      end

      if (cmd_i.valid && cmd_i.ready) begin
        hit = 1'b0;
        case (cmd_i.func)
          FUNC_START: begin
            goal[0] = cmd_i.target_red;
            goal[1] = cmd_i.target_green;
            goal[2] = cmd_i.target_blue;
            fade_ms = cmd_i.duration_ms;
            start_fade();
          end
          FUNC_RESTART: start_fade();
          FUNC_TICK: if (fading) hit = tick_lanes();
          default: ;
        endcase
        if (hit) fades_done_o++;
        want.red     = whole(level[0]);
        want.green   = whole(level[1]);
        want.blue    = whole(level[2]);
        want.done    = hit;
        want.running = fading;
        expected_colors.push_back(want);
      end
      pending_o = expected_colors.size();
    end
  end

endmodule

/* sim/tb_rgb_linear_fade_engine.sv */
`timescale 1ns / 100ps
// Testbench top for rgb_linear_fade_engine: clock, reset, stimulus and verdict.
// Depends on rlf_pkg, rlf_if, the engine RTL and rlf_fade_checker.

module tb_rgb_linear_fade_engine;
  import rlf_pkg::*;

  // func code with no meaning; the engine must leave the fade alone
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // settling wait, sized with margin for a start or restart still in its two divides
  localparam int SETTLE_CYCLES = 2 * (27 + FRAC_BITS_DEF) + 10;
  localparam int PHASE_ITEMS   = 145;   // seven random phases, at least 1015 items in all
  localparam int MAX_RAMP      = 40;    // keeps fades short so they finish

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rlf_cfg_if cfg_ch ();
  rlf_cmd_if cmd_ch ();
  rlf_res_if res_ch ();

  int fail_count;
  int pending;
  int fades_done;

  int sent_by_func [4];
  int items_sent;     // excludes the unused code, which the engine ignores
  int interval_now;   // mirror of the register, used to size ramps
  int ramp_steps;     // tick count planned by the latest start
  int settings_used;
  bit no_idle;        // set for phases that run both sides flat out

  rgb_linear_fade_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  rlf_fade_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_ch),
    .cmd_i        (cmd_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .fades_done_o (fades_done)
  );

  always #2 clk_i = ~clk_i;

  // hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: before each transfer ready is held low at random, never when no_idle is set.
  // Ready only moves at the falling edge, valid is looked at on the rising edge.
  initial begin : result_sink
    int hold;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        res_ch.ready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      @(negedge clk_i);
    end
  end

  // One command transfer. Called at a falling edge, returns at a falling edge.
  // A zero gap leaves valid high so back-to-back transfers are possible.
  task automatic send_command(input logic [FUNC_W-1:0] code,
                              input logic [INT_W-1:0]  r,
                              input logic [INT_W-1:0]  g,
                              input logic [INT_W-1:0]  b,
                              input logic [DUR_W-1:0]  dur);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.func         = code;
    cmd_ch.target_red   = r;
    cmd_ch.target_green = g;
    cmd_ch.target_blue  = b;
    cmd_ch.duration_ms  = dur;
    cmd_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!cmd_ch.ready);
    @(negedge clk_i);
    sent_by_func[code]++;
    if (code != FUNC_UNUSED) items_sent++;
  endtask

  // tick, restart and the unused code ignore the payload, so it is random
  task automatic send_plain(input logic [FUNC_W-1:0] code);
    send_command(code, INT_W'($urandom), INT_W'($urandom), INT_W'($urandom),
                 DUR_W'($urandom));
  endtask

  function automatic logic [INT_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COLOR_MAX;
      default: return INT_W'($urandom);
    endcase
  endfunction

  // Start a fade that takes n ticks at the current interval. The duration gets
  // a random remainder below one interval so the division truncates.
  task automatic start_ramp(input int n);
    int per_tick;
    int dur;
    per_tick   = (interval_now == 0) ? 1 : interval_now;
    dur        = n * per_tick + $urandom_range(0, per_tick - 1);
    if (dur > 65535) dur = 65535;
    ramp_steps = n;
    send_command(FUNC_START, pick_color(), pick_color(), pick_color(), DUR_W'(dur));
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] v);
    cfg_ch.update_interval_ms = v;
    cfg_ch.valid              = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
    interval_now = v;
    settings_used++;
  endtask

  // Drain: stop sending, wait for every expected result, then let the
  // engine's internal work settle before touching the register.
  task automatic quiesce();
    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly complete fades (start, enough ticks to arrive, a few idle ticks),
  // sometimes cut short, restarted midway, or mixed with noise items.
  task automatic random_phase(input int budget);
    int stop_at;
    int pick;
    int n;
    int extra;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        n = $urandom_range(1, MAX_RAMP);
        start_ramp(n);
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n)
                                            : n + $urandom_range(0, 3);
        repeat (extra) send_plain(FUNC_TICK);
        if ($urandom_range(0, 5) == 0) begin
          send_plain(FUNC_RESTART);
          repeat (n + 2) send_plain(FUNC_TICK);
        end
      end else if (pick == 7) begin
        // restart reuses the stored target and duration
        send_plain(FUNC_RESTART);
        repeat (ramp_steps + 2) send_plain(FUNC_TICK);
      end else if (pick == 8) begin
        // noise: any code, any payload, full-range durations included
        repeat ($urandom_range(1, 3))
          send_command(FUNC_W'($urandom_range(0, 3)), INT_W'($urandom),
                       INT_W'($urandom), INT_W'($urandom), DUR_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 3))
          send_plain(($urandom_range(0, 1) == 0) ? FUNC_TICK : FUNC_UNUSED);
      end
    end
  endtask

  initial begin : stimulus
    logic [IVL_W-1:0] phase_ivl [7];

    cmd_ch.valid              = 1'b0;
    cmd_ch.func               = FUNC_TICK;
    cmd_ch.target_red         = '0;
    cmd_ch.target_green       = '0;
    cmd_ch.target_blue        = '0;
    cmd_ch.duration_ms        = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.update_interval_ms = '0;
    interval_now              = int'(IVL_RESET);
    no_idle                   = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed, interval at its reset value ----
    send_plain(FUNC_TICK);                 // tick with no fade: nothing moves
    send_plain(FUNC_UNUSED);               // unused code while idle
    send_plain(FUNC_RESTART);              // stored goal and duration still zero
    send_plain(FUNC_TICK);                 // already on goal: done at once
    // zero duration means a single step to full white
    send_command(FUNC_START, COLOR_MAX, COLOR_MAX, COLOR_MAX, '0);
    send_plain(FUNC_TICK);
    // duration equal to the interval, one step, two channels down and one already on goal
    send_command(FUNC_START, '0, 8'd128, COLOR_MAX, 16'd20);
    send_plain(FUNC_TICK);
    // longest duration: quotient underflows, steps become one LSB
    send_command(FUNC_START, 8'd1, 8'd127, 8'd254, '1);
    repeat (3) send_plain(FUNC_TICK);
    send_plain(FUNC_UNUSED);               // unused code mid-fade keeps running
    send_plain(FUNC_RESTART);              // snaps levels, recomputes steps
    repeat (2) send_plain(FUNC_TICK);
    // three steps with truncation, then one spare tick
    send_command(FUNC_START, 8'd170, 8'd85, '0, 16'd60);
    repeat (4) send_plain(FUNC_TICK);
    send_command(FUNC_START, COLOR_MAX, '0, COLOR_MAX, 16'd40);
    repeat (3) send_plain(FUNC_TICK);
    quiesce();

    // ---- random phases, one interval setting each ----
    phase_ivl[0] = IVL_W'(1);
    phase_ivl[1] = IVL_W'(1023);
    phase_ivl[2] = IVL_W'(0);              // behaves as one
    phase_ivl[3] = IVL_W'(1000);
    phase_ivl[4] = IVL_W'($urandom_range(2, 999));
    phase_ivl[5] = IVL_W'($urandom_range(0, 1023));
    phase_ivl[6] = IVL_RESET;
    for (int p = 0; p < 7; p++) begin
      write_interval(phase_ivl[p]);
      no_idle = (p == 1 || p == 4);
      random_phase(PHASE_ITEMS);
      quiesce();
    end
    no_idle = 1'b0;

    $display("ran %0d starts, %0d restarts, %0d ticks, %0d unused-code items; %0d fades done",
             sent_by_func[FUNC_START], sent_by_func[FUNC_RESTART], sent_by_func[FUNC_TICK],
             sent_by_func[FUNC_UNUSED], fades_done);
    $display("over %0d interval settings, including 0, 1, 1023 and the reset value",
             settings_used + 1);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
